// File: rtl/hbs_pkg.sv
package hbs_pkg;

  localparam int TIME_W = 48;
  localparam logic [15:0] FEED_PERIOD_RST = 16'd1000;

  typedef enum logic [1:0] {
    MODE_BEAT   = 2'd0,
    MODE_TICK   = 2'd1,
    MODE_REBOOT = 2'd2,
    MODE_NONE   = 2'd3
  } hbs_mode_e;

  localparam logic [2:0] REASON_NONE      = 3'd0;
  localparam logic [2:0] REASON_TASK_HUNG = 3'd5;
  localparam logic [2:0] REASON_INVALID   = 3'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_RESULT
  } hbs_state_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  task_id;
    logic [31:0] age_limit;
    logic [2:0]  request_reason;
  } hbs_in_t;

  typedef struct packed {
    logic       check_done;
    logic       feed_watchdog;
    logic       reboot_now;
    logic [2:0] reboot_reason;
    logic       hung_found;
    logic [7:0] hung_task;
    logic       beat_dropped;
    logic [2:0] marker_reason;
  } hbs_out_t;

  // Query token that walks the slot chain, one cell per cycle.
  typedef struct packed {
    logic              active;
    logic              scan;      // 1: stale scan, 0: heartbeat lookup/insert
    logic [7:0]        task_id;
    logic [31:0]       age_limit;
    logic [TIME_W-1:0] time_ms;
    logic              found;
    logic              inserted;
    logic              hung;
    logic [7:0]        hung_task;
  } hbs_tok_t;

endpackage

// File: rtl/heartbeat_supervisor_top.sv
// Heartbeat supervisor: tracks liveness of up to MAX_SLOTS tasks.
// Input channel (in_valid_i / in_stall_o / in_data_i) carries one transaction per
// event: a heartbeat, a 1 ms tick or a reboot request. Every input transaction
// yields exactly one result transaction on out_valid_o / out_stall_i / out_data_o.
// Slots sit in a row of cells; heartbeat lookup/insert and the periodic stale
// scan send a token down that row, one cell per cycle. Ticks without a scan,
// forced reboots and reboot requests skip the row and go straight to the
// result register. One item is worked on at a time: the next is accepted
// once the current result is handed to the output register. If the receiver
// stalls, the result holds in the output register and one more item can be
// processed behind it.
// cfg_we_i / cfg_wdata_i write feed_period_ms (0 acts as 1); write it only
// while idle. Reset clears time, period count, slot count, pending request
// and marker, and sets the feed period to 1000 ms. No clearing pass is needed.
module heartbeat_supervisor_top #(
  parameter int MAX_SLOTS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  hbs_pkg::hbs_in_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output hbs_pkg::hbs_out_t out_data_o,
  input  logic             cfg_we_i,
  input  logic [15:0]      cfg_wdata_i
);
  import hbs_pkg::*;

  localparam int UW = $clog2(MAX_SLOTS + 1);

  hbs_state_e        state_q, state_d;
  logic [TIME_W-1:0] time_q, time_d;
  logic [15:0]       pcount_q, pcount_d;
  logic [UW-1:0]     used_q, used_d;
  logic [2:0]        pending_q, pending_d;
  logic [2:0]        marker_q, marker_d;
  logic [15:0]       period_q;
  hbs_tok_t          tok_q, tok_d;
  hbs_out_t          res_q, res_d;
  hbs_out_t          out_q;
  logic              out_valid_q;

  hbs_tok_t          chain [MAX_SLOTS+1];
  hbs_tok_t          tail;

  logic              in_acc, out_free, go_walk, check;
  logic [15:0]       period, pc_inc;
  logic [TIME_W-1:0] time_inc;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign period   = (period_q == 16'd0) ? 16'd1 : period_q;
  assign pc_inc   = pcount_q + 16'd1;
  assign check    = (pc_inc >= period);
  assign time_inc = time_q + TIME_W'(1);

  // Heartbeats always walk the chain; ticks walk only for a stale scan.
  always_comb begin
    case (hbs_mode_e'(in_data_i.mode))
      MODE_BEAT: go_walk = 1'b1;
      MODE_TICK: go_walk = check && (pending_q == REASON_NONE);
      default:   go_walk = 1'b0;
    endcase
  end

  assign chain[0] = tok_q;
  assign tail     = chain[MAX_SLOTS];

  for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
    hbs_cell #(
      .IDX (g),
      .UW  (UW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .slot_used_i (used_q),
      .tok_i       (chain[g]),
      .tok_o       (chain[g+1])
    );
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = go_walk ? ST_WALK : ST_RESULT;
        end
      end
      ST_WALK: begin
        if (tail.active) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath
  always_comb begin
    time_d    = time_q;
    pcount_d  = pcount_q;
    used_d    = used_q;
    pending_d = pending_q;
    marker_d  = marker_q;
    res_d     = res_q;
    tok_d     = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          res_d = '0;
          tok_d.task_id   = in_data_i.task_id;
          tok_d.age_limit = in_data_i.age_limit;
          tok_d.time_ms   = time_q;
          case (hbs_mode_e'(in_data_i.mode))
            MODE_BEAT: begin
              tok_d.active = 1'b1;
            end
            MODE_TICK: begin
              time_d   = time_inc;
              pcount_d = check ? 16'd0 : pc_inc;
              if (check) begin
                if (pending_q != REASON_NONE) begin
                  res_d.check_done    = 1'b1;
                  res_d.reboot_now    = 1'b1;
                  res_d.reboot_reason = pending_q;
                  marker_d            = pending_q;
                  pending_d           = REASON_NONE;
                end else begin
                  tok_d.active  = 1'b1;
                  tok_d.scan    = 1'b1;
                  tok_d.time_ms = time_inc;
                end
              end
            end
            MODE_REBOOT: begin
              if (pending_q == REASON_NONE && in_data_i.request_reason != REASON_NONE &&
                  in_data_i.request_reason != REASON_INVALID) begin
                pending_d = in_data_i.request_reason;
              end
            end
            default: ;
          endcase
          res_d.marker_reason = marker_d;
        end
      end
      ST_WALK: begin
        if (tail.active) begin
          res_d = '0;
          if (tail.scan) begin
            res_d.check_done = 1'b1;
            if (tail.hung) begin
              res_d.hung_found = 1'b1;
              res_d.hung_task  = tail.hung_task;
              marker_d         = REASON_TASK_HUNG;
            end else begin
              res_d.feed_watchdog = 1'b1;
            end
          end else begin
            if (tail.inserted) begin
              used_d = used_q + UW'(1);
            end
            res_d.beat_dropped = !tail.found;
          end
          res_d.marker_reason = marker_d;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      time_q      <= '0;
      pcount_q    <= '0;
      used_q      <= '0;
      pending_q   <= REASON_NONE;
      marker_q    <= REASON_NONE;
      period_q    <= FEED_PERIOD_RST;
      tok_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      time_q    <= time_d;
      pcount_q  <= pcount_d;
      used_q    <= used_d;
      pending_q <= pending_d;
      marker_q  <= marker_d;
      tok_q     <= tok_d;
      if (cfg_we_i) begin
        period_q <= cfg_wdata_i;
      end
      if (state_q == ST_RESULT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (state_q == ST_RESULT && out_free) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/hbs_cell.sv
module hbs_cell #(
  parameter int IDX = 0,
  parameter int UW  = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [UW-1:0]    slot_used_i,
  input  hbs_pkg::hbs_tok_t tok_i,
  output hbs_pkg::hbs_tok_t tok_o
);
  import hbs_pkg::*;

  logic [7:0]        task_q;
  logic [TIME_W-1:0] last_q;
  logic [31:0]       limit_q;
  hbs_tok_t          tok_q, tok_d;
  logic              used, match, ins, stale, wr;
  logic [TIME_W-1:0] age;

  assign used  = UW'(IDX) < slot_used_i;
  assign match = used && (tok_i.task_id == task_q);
  assign ins   = !used && (UW'(IDX) == slot_used_i);
  assign age   = tok_i.time_ms - last_q;
  assign stale = used && (age > {{(TIME_W-32){1'b0}}, limit_q});

  always_comb begin
    tok_d = tok_i;
    wr    = 1'b0;
    if (tok_i.active) begin
      if (!tok_i.scan) begin
        if (!tok_i.found && (match || ins)) begin
          wr             = 1'b1;
          tok_d.found    = 1'b1;
          tok_d.inserted = ins;
        end
      end else if (!tok_i.hung && stale) begin
        tok_d.hung      = 1'b1;
        tok_d.hung_task = task_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      task_q  <= tok_i.task_id;
      last_q  <= tok_i.time_ms;
      limit_q <= tok_i.age_limit;
    end
  end

  assign tok_o = tok_q;

endmodule

// File: verif/heartbeat_supervisor_top_tb.sv
`timescale 1ns / 1ps

module heartbeat_supervisor_top_tb;
  import hbs_pkg::*;

  localparam int SLOTS       = 16;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  hbs_in_t     in_data     = '0;
  logic        in_stall;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  hbs_out_t    out_data;
  logic        cfg_we      = 1'b0;
  logic [15:0] cfg_wdata   = '0;

  logic        gaps_on     = 1'b1;
  logic        hold_toggle = 1'b0;
  logic        hold_ack    = 1'b0;
  int          hold_left   = 0;
  int          quiet_cycles = 0;
  int          errors      = 0;

  hbs_out_t    outcomes_due[$];
  hbs_out_t    want_out;

  // supervisor state as the block should hold it
  logic [47:0] time_now     = '0;
  logic [15:0] tick_count   = '0;
  int          slots_used   = 0;
  logic [7:0]  slot_id      [SLOTS];
  logic [47:0] slot_beat    [SLOTS];
  logic [31:0] slot_max_age [SLOTS];
  logic [2:0]  pending_req  = REASON_NONE;
  logic [2:0]  marker       = REASON_NONE;
  logic [15:0] feed_period  = FEED_PERIOD_RST;

  heartbeat_supervisor_top #(
    .MAX_SLOTS(SLOTS)
  ) uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Applies one event to the supervisor state and returns the outcome it causes.
  function automatic hbs_out_t supervise(input hbs_in_t ev);
    hbs_out_t    res;
    logic        found;
    logic [15:0] per;
    logic [47:0] age;
    res = '0;
    case (ev.mode)
      MODE_BEAT: begin
        found = 1'b0;
        for (int i = 0; i < slots_used && !found; i++) begin
          if (slot_id[i] == ev.task_id) begin
            slot_beat[i]    = time_now;
            slot_max_age[i] = ev.age_limit;
            found = 1'b1;
          end
        end
        if (!found) begin
          if (slots_used < SLOTS) begin
            slot_id[slots_used]      = ev.task_id;
            slot_beat[slots_used]    = time_now;
            slot_max_age[slots_used] = ev.age_limit;
            slots_used++;
          end else begin
            res.beat_dropped = 1'b1;
          end
        end
      end
      MODE_TICK: begin
        per = (feed_period == 16'd0) ? 16'd1 : feed_period;
        time_now   = time_now + 48'd1;
        tick_count = tick_count + 16'd1;
        if (tick_count >= per) begin
          tick_count     = '0;
          res.check_done = 1'b1;
          if (pending_req != REASON_NONE) begin
            res.reboot_now    = 1'b1;
            res.reboot_reason = pending_req;
            marker            = pending_req;
            pending_req       = REASON_NONE;
          end else begin
            // first stale slot in insertion order wins
            for (int i = 0; i < slots_used && !res.hung_found; i++) begin
              age = time_now - slot_beat[i];
              if (age > {16'd0, slot_max_age[i]}) begin
                res.hung_found = 1'b1;
                res.hung_task  = slot_id[i];
              end
            end
            if (res.hung_found) marker = REASON_TASK_HUNG;
            else res.feed_watchdog = 1'b1;
          end
        end
      end
      MODE_REBOOT: begin
        if (pending_req == REASON_NONE && ev.request_reason != REASON_NONE &&
            ev.request_reason != REASON_INVALID) begin
          pending_req = ev.request_reason;
        end
      end
      default: ;
    endcase
    res.marker_reason = marker;
    return res;
  endfunction

  function automatic hbs_in_t make_event(input hbs_mode_e m, input logic [7:0] id,
                                         input logic [31:0] age, input logic [2:0] why);
    hbs_in_t ev;
    ev.mode           = m;
    ev.task_id        = id;
    ev.age_limit      = age;
    ev.request_reason = why;
    return ev;
  endfunction

  function automatic hbs_in_t random_event(input int span);
    hbs_in_t ev;
    int      pick;
    pick = $urandom_range(99);
    ev.mode = (pick < 45) ? MODE_TICK : (pick < 85) ? MODE_BEAT :
              (pick < 95) ? MODE_REBOOT : MODE_NONE;
    ev.task_id = 8'($urandom_range(span));
    pick = $urandom_range(9);
    ev.age_limit = (pick == 0) ? $urandom() :
                   (pick < 3) ? $urandom_range(3) : $urandom_range(40, 5);
    ev.request_reason = 3'($urandom_range(7));
    return ev;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  // Offers one event and holds it until the block takes it; valid stays high on return.
  task automatic send_event(input hbs_in_t ev);
    if (gaps_on && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    do @(posedge clk); while (in_stall);
    outcomes_due.push_back(supervise(ev));
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_period(input logic [15:0] p);
    wait_drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= p;
    @(posedge clk);
    cfg_we    <= 1'b0;
    feed_period = p;
  endtask

  task automatic send_tick();
    send_event(make_event(MODE_TICK, 8'h00, 32'h0, REASON_NONE));
  endtask

  task automatic test_default_period();
    repeat (3) send_tick();
  endtask

  // count sits above the new, smaller period: the next tick must check
  task automatic test_period_lowered();
    set_period(16'hFFFF);
    repeat (4) send_tick();
    set_period(16'd2);
    send_tick();
  endtask

  task automatic test_slot_table();
    send_event(make_event(MODE_BEAT, 8'h00, 32'hFFFF_FFFF, REASON_NONE));
    send_event(make_event(MODE_BEAT, 8'hFF, 32'h0, 3'd7));
    send_event(make_event(MODE_BEAT, 8'hFF, 32'd2, REASON_NONE));
    send_event(make_event(MODE_NONE, 8'hFF, 32'hFFFF_FFFF, 3'd7));
    repeat (4) send_tick();
  endtask

  task automatic test_reboot_requests();
    send_event(make_event(MODE_REBOOT, 8'hFF, 32'hFFFF_FFFF, REASON_NONE));
    send_event(make_event(MODE_REBOOT, 8'hFF, 32'hFFFF_FFFF, REASON_INVALID));
    send_event(make_event(MODE_REBOOT, 8'h00, 32'h0, 3'd3));
    send_event(make_event(MODE_REBOOT, 8'h00, 32'h0, 3'd6));
    repeat (4) send_tick();
  endtask

  task automatic test_zero_period();
    set_period(16'd0);
    repeat (3) send_tick();
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    set_period(16'd1);
    hold_toggle <= ~hold_toggle;
    repeat (12) send_event(random_event(10));
    wait_drain();
  endtask

  task automatic run_random(input logic [15:0] p, input int span, input int count,
                            input logic gaps);
    set_period(p);
    gaps_on <= gaps;
    repeat (count) send_event(random_event(span));
  endtask

  task automatic test_random_traffic();
    run_random(16'd1, 10, 150, 1'b1);
    run_random(16'd3, 10, 150, 1'b0);
    run_random(16'd0, 40, 150, 1'b1);
    run_random(16'd7, 255, 150, 1'b1);
    run_random(16'd1, 255, 150, 1'b1);
  endtask

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_toggle != hold_ack) begin
      hold_ack  <= hold_toggle;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= gaps_on && ($urandom_range(99) < 16);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (outcomes_due.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
      end else begin
        want_out = outcomes_due.pop_front();
        check_field("check_done", want_out.check_done, out_data.check_done);
        check_field("feed_watchdog", want_out.feed_watchdog, out_data.feed_watchdog);
        check_field("reboot_now", want_out.reboot_now, out_data.reboot_now);
        check_field("reboot_reason", want_out.reboot_reason, out_data.reboot_reason);
        check_field("hung_found", want_out.hung_found, out_data.hung_found);
        check_field("hung_task", want_out.hung_task, out_data.hung_task);
        check_field("beat_dropped", want_out.beat_dropped, out_data.beat_dropped);
        check_field("marker_reason", want_out.marker_reason, out_data.marker_reason);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_period();
    test_period_lowered();
    test_slot_table();
    test_reboot_requests();
    test_zero_period();
    test_backpressure();
    test_random_traffic();
    wait_drain();
    repeat (SLOTS + 3) @(posedge clk);
    if (errors == 0 && outcomes_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/hbs_pkg.sv
rtl/hbs_cell.sv
rtl/heartbeat_supervisor_top.sv
verif/heartbeat_supervisor_top_tb.sv
